// ===== design/dpcm_image_decoder_gap_unit_macros.svh =====
// Assertion helpers for the checker file.
`ifndef DPCM_IMAGE_DECODER_GAP_UNIT_MACROS_SVH
`define DPCM_IMAGE_DECODER_GAP_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define DIG_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("dig check failed");

// next-cycle implication, off during reset
`define DIG_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("dig check failed");

// next-cycle implication, always on
`define DIG_ASSERT_NXT_ON(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("dig check failed");

`endif

// ===== design/dig_pkg.sv =====
package dig_pkg;

  localparam int PIXEL_BITS = 8;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  // register map, index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_PREDICT_RULE = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2,
    REG_MAX_GRAY     = 2'd3
  } reg_index_t;

  localparam logic [2:0] RULE_WEST     = 3'd1;
  localparam logic [2:0] RULE_NORTH    = 3'd2;
  localparam logic [2:0] RULE_AVERAGE  = 3'd3;
  localparam logic [2:0] RULE_GRADIENT = 3'd4;

  localparam logic [1:0] MODE_COPY   = 2'd0;
  localparam logic [1:0] MODE_BINARY = 2'd1;

  // causal neighborhood of the current pixel
  typedef struct packed {
    pixel_t w;
    pixel_t ww;
    pixel_t nw;
    pixel_t n;
    pixel_t ne;
    pixel_t nn;
    pixel_t nne;
  } nbr_t;

  // position class of the current pixel
  typedef struct packed {
    logic first;       // row 0, column 0
    logic row0;        // row 0
    logic north_edge;  // row 1, columns 0/1, last column
  } pos_t;

endpackage

// ===== design/dpcm_image_decoder_gap_unit.sv =====
// Result valid rises in the cycle after a residual transfer, while the output is free.
// Throughput: one pixel per cycle while input ready is high, set by the west-pixel
// feedback through the predictor; line store reads are addressed from the next position.
// A held result lets one more transfer into a skid entry, then input ready drops.
// Reset (synchronous, rst high): position to row 0 column 0, west pixels to 0,
// registers to defaults, output buffer empty; the line store is not cleared.
module dpcm_image_decoder_gap_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  // residual channel
  input  logic                item_valid,
  output logic                item_ready,
  input  logic signed [10:0]  residual,
  input  logic [1:0]          mode_flag,
  // result channel
  output logic                result_valid,
  input  logic                result_ready,
  output dig_pkg::pixel_t     pixel,
  output logic                clamped,
  output logic                last_pixel,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import dig_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int AW = $clog2(3 * MAX_WIDTH);
  localparam int WB = (CW + 1 > 11) ? CW + 1 : 11;

  typedef logic [CW-1:0] col_t;
  typedef logic [AW-1:0] addr_t;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [2:0]  predict_rule;
  logic [10:0] image_width;
  logic [12:0] image_height;
  pixel_t      gray_limit;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      predict_rule <= RULE_WEST;
      image_width  <= 11'd1024;
      image_height <= 13'd1024;
      gray_limit   <= 8'd255;
    end else if (cfg_write) begin
      unique case (reg_index_t'(paddr[3:2]))
        REG_PREDICT_RULE: predict_rule <= pwdata[2:0];
        REG_IMAGE_WIDTH:  image_width  <= pwdata[10:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[12:0];
        REG_MAX_GRAY:     gray_limit   <= pwdata[PIXEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_t'(paddr[3:2]))
      REG_PREDICT_RULE: prdata = 32'(predict_rule);
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      REG_MAX_GRAY:     prdata = 32'(gray_limit);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Effective image size. Out-of-range sizes are clipped; the last
  // column / row compare is ">=" so a mid-image shrink still wraps.
  // ---------------------------------------------------------------
  logic [WB-1:0] width_eff;
  logic [12:0]   height_eff;

  always_comb begin
    width_eff = WB'(image_width);
    if (width_eff < WB'(3)) begin
      width_eff = WB'(3);
    end else if (width_eff > WB'(MAX_WIDTH)) begin
      width_eff = WB'(MAX_WIDTH);
    end
    height_eff = image_height;
    if (height_eff == 13'd0) begin
      height_eff = 13'd1;
    end else if (height_eff > 13'd4096) begin
      height_eff = 13'd4096;
    end
  end

  // ---------------------------------------------------------------
  // Raster position. slot tracks row mod 3, the line store row that
  // the current row is written into.
  // ---------------------------------------------------------------
  col_t        col, col_next;
  logic [11:0] row, row_next;
  logic [1:0]  slot, slot_next;
  logic        last_col, last_row, accept;
  logic        skid_valid;

  assign item_ready = !skid_valid;
  assign accept     = item_valid && item_ready;

  assign last_col = WB'(col) >= (width_eff - WB'(1));
  assign last_row = {1'b0, row} >= (height_eff - 13'd1);

  always_comb begin
    col_next  = col;
    row_next  = row;
    slot_next = slot;
    if (accept) begin
      if (last_col) begin
        col_next = '0;
        if (last_row) begin
          row_next  = '0;
          slot_next = 2'd0;
        end else begin
          row_next  = row + 12'd1;
          slot_next = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
        end
      end else begin
        col_next = col + col_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      slot <= 2'd0;
    end else begin
      col  <= col_next;
      row  <= row_next;
      slot <= slot_next;
    end
  end

  // ---------------------------------------------------------------
  // Line store: three rows of MAX_WIDTH pixels, one write and two
  // registered reads per cycle. Reads are addressed from the next
  // position so that the read registers always hold, for the current
  // position, port A = N row at col+1 (NE) and port B = NN row at col+1
  // (NNE). At column 0 port B fetches N at col 0 instead, since no
  // NN/NNE is needed there. N, NW and NN then follow by shifting.
  // ---------------------------------------------------------------
  function automatic addr_t row_base(input logic [1:0] s);
    case (s)
      2'd0:    return '0;
      2'd1:    return AW'(MAX_WIDTH);
      default: return AW'(2 * MAX_WIDTH);
    endcase
  endfunction

  pixel_t     store [3*MAX_WIDTH];
  pixel_t     rd_ne, rd_nb;
  col_t       rd_col, rd_col_p1;
  logic [1:0] rd_slot, rd_up, rd_up2;
  addr_t      addr_a, addr_b, addr_w;
  pixel_t     pix_new;
  logic       clamp_new;

  assign rd_col    = rst ? '0 : col_next;
  assign rd_slot   = rst ? 2'd0 : slot_next;
  assign rd_col_p1 = (WB'(rd_col) == WB'(MAX_WIDTH - 1)) ? '0 : rd_col + col_t'(1);
  assign rd_up     = (rd_slot == 2'd0) ? 2'd2 : rd_slot - 2'd1;
  assign rd_up2    = (rd_slot == 2'd2) ? 2'd0 : rd_slot + 2'd1;
  assign addr_a    = row_base(rd_up) + AW'(rd_col_p1);
  assign addr_b    = (rd_col == '0) ? row_base(rd_up) : row_base(rd_up2) + AW'(rd_col_p1);
  assign addr_w    = row_base(slot) + AW'(col);

  always_ff @(posedge clk) begin
    rd_ne <= store[addr_a];
    rd_nb <= store[addr_b];
    if (accept) begin
      store[addr_w] <= pix_new;
    end
  end

  // ---------------------------------------------------------------
  // Neighborhood registers
  // ---------------------------------------------------------------
  pixel_t w_pix, ww_pix;       // reset to zero
  pixel_t n_pix, nw_pix, nn_pix;
  nbr_t   nbr;
  pos_t   pos;

  always_comb begin
    nbr.w   = w_pix;
    nbr.ww  = ww_pix;
    nbr.n   = (col == '0) ? rd_nb : n_pix;
    nbr.nw  = nw_pix;
    nbr.ne  = rd_ne;
    nbr.nn  = nn_pix;
    nbr.nne = rd_nb;
    pos.first      = (row == '0) && (col == '0);
    pos.row0       = (row == '0);
    pos.north_edge = (row == 12'd1) || (WB'(col) <= WB'(1)) || last_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_pix  <= '0;
      ww_pix <= '0;
    end else if (accept) begin
      w_pix  <= pix_new;
      ww_pix <= w_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      nw_pix <= nbr.n;
      n_pix  <= rd_ne;
      nn_pix <= rd_nb;
    end
  end

  dig_predict u_predict (
    .nbr        (nbr),
    .pos        (pos),
    .rule       (predict_rule),
    .mode_flag  (mode_flag),
    .residual   (residual),
    .gray_limit (gray_limit),
    .pixel      (pix_new),
    .clamped    (clamp_new)
  );

  // ---------------------------------------------------------------
  // Output buffer: result register plus one skid entry. The skid
  // entry fills only when a transfer arrives while the result register
  // is held; input ready drops while it is occupied.
  // ---------------------------------------------------------------
  pixel_t skid_pixel;
  logic   skid_clamped, skid_last;
  logic   out_fire, last_new;

  assign out_fire = result_valid && result_ready;
  assign last_new = last_col && last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (result_valid && !result_ready) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (out_fire) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        pixel      <= skid_pixel;
        clamped    <= skid_clamped;
        last_pixel <= skid_last;
      end
    end else if (accept) begin
      if (result_valid && !result_ready) begin
        skid_pixel   <= pix_new;
        skid_clamped <= clamp_new;
        skid_last    <= last_new;
      end else begin
        pixel      <= pix_new;
        clamped    <= clamp_new;
        last_pixel <= last_new;
      end
    end
  end

endmodule

// ===== design/dig_predict.sv =====
module dig_predict (
  input  dig_pkg::nbr_t      nbr,
  input  dig_pkg::pos_t      pos,
  input  logic [2:0]         rule,
  input  logic [1:0]         mode_flag,
  input  logic signed [10:0] residual,
  input  dig_pkg::pixel_t    gray_limit,
  output dig_pkg::pixel_t    pixel,
  output logic               clamped
);
  import dig_pkg::*;

  typedef logic signed [11:0] sval_t;

  localparam sval_t FIRST_PRED = 12'sd128;
  localparam sval_t THR_HARD   = 12'sd80;
  localparam sval_t THR_HALF   = 12'sd32;
  localparam sval_t THR_SOFT   = 12'sd8;

  function automatic pixel_t absdiff(input pixel_t a, input pixel_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  // divide by 2 / 4, truncating toward zero
  function automatic sval_t half_tz(input sval_t x);
    sval_t t;
    t = x + $signed({11'b0, x[11]});
    return t >>> 1;
  endfunction

  function automatic sval_t quarter_tz(input sval_t x);
    sval_t t;
    t = x + $signed({10'b0, x[11], x[11]});
    return t >>> 2;
  endfunction

  logic [9:0]         dh, dv;
  sval_t              diff_vh, diff_hv;
  logic [8:0]         sum_wn;
  sval_t              w_s, n_s, avg_s, p_base, p3, grad, pred;
  logic               direct;
  pixel_t             direct_pix, bin_pix;
  logic signed [12:0] raw;

  assign w_s   = $signed({4'b0, nbr.w});
  assign n_s   = $signed({4'b0, nbr.n});
  assign sum_wn = {1'b0, nbr.w} + {1'b0, nbr.n};
  assign avg_s = $signed({4'b0, sum_wn[8:1]});

  assign dh = 10'(absdiff(nbr.w, nbr.ww)) + 10'(absdiff(nbr.n, nbr.nw))
            + 10'(absdiff(nbr.ne, nbr.n));
  assign dv = 10'(absdiff(nbr.w, nbr.nw)) + 10'(absdiff(nbr.n, nbr.nn))
            + 10'(absdiff(nbr.ne, nbr.nne));
  assign diff_vh = $signed({2'b0, dv}) - $signed({2'b0, dh});
  assign diff_hv = $signed({2'b0, dh}) - $signed({2'b0, dv});

  assign p_base = avg_s + quarter_tz($signed({4'b0, nbr.ne}) - $signed({4'b0, nbr.nw}));
  assign p3     = (p_base <<< 1) + p_base;

  always_comb begin
    if (diff_vh > THR_HARD) begin
      grad = w_s;
    end else if (diff_hv > THR_HARD) begin
      grad = n_s;
    end else if (diff_vh > THR_HALF) begin
      grad = half_tz(p_base + w_s);
    end else if (diff_hv > THR_HALF) begin
      grad = half_tz(p_base + n_s);
    end else if (diff_vh > THR_SOFT) begin
      grad = quarter_tz(p3 + w_s);
    end else if (diff_hv > THR_SOFT) begin
      grad = quarter_tz(p3 + n_s);
    end else begin
      grad = p_base;
    end
  end

  // binary pick: first of NNE, NE, NN, N, NW, WW that differs from W, else W
  always_comb begin
    if (nbr.nne != nbr.w) begin
      bin_pix = nbr.nne;
    end else if (nbr.ne != nbr.w) begin
      bin_pix = nbr.ne;
    end else if (nbr.nn != nbr.w) begin
      bin_pix = nbr.nn;
    end else if (nbr.n != nbr.w) begin
      bin_pix = nbr.n;
    end else if (nbr.nw != nbr.w) begin
      bin_pix = nbr.nw;
    end else if (nbr.ww != nbr.w) begin
      bin_pix = nbr.ww;
    end else begin
      bin_pix = nbr.w;
    end
  end

  always_comb begin
    direct     = 1'b0;
    direct_pix = nbr.w;
    pred       = w_s;
    if (pos.first) begin
      pred = FIRST_PRED;
    end else if (pos.row0) begin
      pred = w_s;
    end else if (pos.north_edge) begin
      pred = n_s;
    end else begin
      unique case (rule)
        RULE_NORTH:   pred = n_s;
        RULE_AVERAGE: pred = avg_s;
        RULE_GRADIENT: begin
          case (mode_flag)
            MODE_COPY: begin
              direct = 1'b1;
            end
            MODE_BINARY: begin
              direct     = 1'b1;
              direct_pix = bin_pix;
            end
            default: pred = grad;
          endcase
        end
        default: pred = w_s;
      endcase
    end
  end

  assign raw = {pred[11], pred} + {{2{residual[10]}}, residual};

  always_comb begin
    if (direct) begin
      pixel   = direct_pix;
      clamped = 1'b0;
    end else if (raw < 13'sd0) begin
      pixel   = '0;
      clamped = 1'b1;
    end else if (raw > $signed({5'b0, gray_limit})) begin
      pixel   = gray_limit;
      clamped = 1'b1;
    end else begin
      pixel   = raw[PIXEL_BITS-1:0];
      clamped = 1'b0;
    end
  end

endmodule

// ===== design/dig_checker.sv =====
`include "dpcm_image_decoder_gap_unit_macros.svh"

module dig_checker (
  input logic            clk,
  input logic            rst,
  input logic            item_valid,
  input logic            item_ready,
  input logic            result_valid,
  input logic            result_ready,
  input dig_pkg::pixel_t pixel,
  input logic            clamped,
  input logic            last_pixel
);

  logic                           held;
  logic [dig_pkg::PIXEL_BITS+1:0] payload;

  assign held    = result_valid && !result_ready;
  assign payload = {pixel, clamped, last_pixel};

  // buffer comes out of reset empty
  `DIG_ASSERT_NXT_ON(a_reset_empty, clk, rst, !result_valid)

  // every input transfer leaves a result pending
  `DIG_ASSERT_NXT(a_accept_result, clk, rst, item_valid && item_ready, result_valid)

  // input stalls only behind a held result
  `DIG_ASSERT_IMP(a_stall_cause, clk, rst, !item_ready, result_valid)

  // a held result keeps its payload
  `DIG_ASSERT_NXT(a_result_hold, clk, rst, held, result_valid && $stable(payload))

endmodule

bind dpcm_image_decoder_gap_unit dig_checker u_dig_checker (.*);

// ===== sim/dpcm_image_decoder_gap_unit_tb.sv =====
module dpcm_image_decoder_gap_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dig_pkg::*;

  localparam int MAX_W        = 1024;
  localparam int MAX_H        = 4096;
  localparam int FIRST_GUESS  = 128;  // prediction for the first pixel of an image
  localparam int EDGE_STRONG  = 80;   // gradient gap that picks W or N outright
  localparam int EDGE_MID     = 32;   // gap for the half blend
  localparam int EDGE_WEAK    = 8;    // gap for the three-quarter blend
  localparam int IDLE_PCT     = 37;
  localparam int RANDOM_ITEMS = 1300;

  // mode codes the package leaves unnamed
  localparam logic [1:0] MODE_CONT  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;  // acts as continuous

  typedef struct packed {
    pixel_t pixel;
    logic   clamped;
    logic   last;
  } decoded_t;

  // one row of the directed table; typed rows carry their own expected pixel
  typedef struct packed {
    logic signed [10:0] res;
    logic [1:0]         mode;
    logic               reconfig;
    logic               typed;
    pixel_t             pixel;
    logic               clamped;
  } vector_t;

  // ---------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic               clk;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic signed [10:0] residual = '0;
  logic [1:0]         mode_flag = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  pixel_t             pixel;
  logic               clamped;
  logic               last_pixel;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // side tags that travel with each residual transfer (typed expectation)
  logic   tag_typed = 1'b0;
  pixel_t tag_pixel = '0;
  logic   tag_clamped = 1'b0;

  dpcm_image_decoder_gap_unit #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .residual(residual),
    .mode_flag(mode_flag),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .pixel(pixel),
    .clamped(clamped),
    .last_pixel(last_pixel),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Decoder mirror: line store, raster position, west pixels, register copies
  // ---------------------------------------------------------------------------
  pixel_t      row_mem [3*MAX_W];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int          west = 0;
  int          west2 = 0;
  logic [2:0]  cfg_rule = RULE_WEST;
  logic [10:0] cfg_width = 11'd1024;
  logic [12:0] cfg_height = 13'd1024;
  logic [7:0]  cfg_gray = 8'd255;

  decoded_t pending_pixels [$];  // expected pixels, oldest first
  int       items_sent = 0;
  int       pixels_seen = 0;
  int       mismatches = 0;
  int       random_items = 0;
  int       src_idle_pct = IDLE_PCT;
  int       sink_idle_pct = IDLE_PCT;
  vector_t  directed [25];

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int store_at(input int unsigned slot, input int unsigned col);
    if (col >= MAX_W) return 0;
    return int'(row_mem[(slot % 3) * MAX_W + col]);
  endfunction

  // Reconstruct one pixel and advance the mirror state.
  function automatic decoded_t decode_pixel(input logic signed [10:0] res,
                                            input logic [1:0] mode);
    int unsigned w, h, col, row, cur, up, up2;
    logic [2:0]  rule;
    logic        at_last_col, at_last_row, direct, clip;
    int          pred, value, n, nw, ne, nn, nne, dh, dv, p, k;
    int          nbr [7];
    decoded_t    d;

    w = cfg_width;
    h = cfg_height;
    if (w < 3) w = 3;
    if (w > MAX_W) w = MAX_W;
    if (h < 1) h = 1;
    if (h > MAX_H) h = MAX_H;

    col = col_pos;
    row = row_pos;
    at_last_col = (col >= w - 1);
    at_last_row = (row >= h - 1);
    cur = row % 3;
    up  = (row + 2) % 3;
    up2 = (row + 1) % 3;
    rule = (cfg_rule >= RULE_WEST && cfg_rule <= RULE_GRADIENT) ? cfg_rule : RULE_WEST;

    pred = 0;
    value = 0;
    direct = 1'b0;
    clip = 1'b0;

    if (row == 0 && col == 0) begin
      pred = FIRST_GUESS;
    end else if (row == 0) begin
      pred = west;
    end else if (row == 1 || col <= 1 || at_last_col) begin
      pred = store_at(up, col);
    end else if (rule == RULE_WEST) begin
      pred = west;
    end else if (rule == RULE_NORTH) begin
      pred = store_at(up, col);
    end else if (rule == RULE_AVERAGE) begin
      pred = (store_at(up, col) + west) / 2;
    end else begin
      n   = store_at(up, col);
      nw  = store_at(up, col - 1);
      ne  = store_at(up, col + 1);
      nn  = store_at(up2, col);
      nne = store_at(up2, col + 1);
      if (mode == MODE_COPY) begin
        direct = 1'b1;
        value = west;
      end else if (mode == MODE_BINARY) begin
        // last neighbor that differs from W wins; all equal keeps W
        nbr[0] = west2;
        nbr[1] = west;
        nbr[2] = nw;
        nbr[3] = n;
        nbr[4] = nn;
        nbr[5] = ne;
        nbr[6] = nne;
        direct = 1'b1;
        value = west;
        for (k = 0; k < 7; k++) begin
          if (nbr[k] != west) value = nbr[k];
        end
      end else begin
        dh = mag(west - west2) + mag(n - nw) + mag(ne - n);
        dv = mag(west - nw) + mag(n - nn) + mag(ne - nne);
        if (dv - dh > EDGE_STRONG) begin
          pred = west;
        end else if (dh - dv > EDGE_STRONG) begin
          pred = n;
        end else begin
          p = (west + n) / 2 + (ne - nw) / 4;
          if (dv - dh > EDGE_MID) p = (p + west) / 2;
          else if (dh - dv > EDGE_MID) p = (p + n) / 2;
          else if (dv - dh > EDGE_WEAK) p = (3 * p + west) / 4;
          else if (dh - dv > EDGE_WEAK) p = (3 * p + n) / 4;
          pred = p;
        end
      end
    end

    if (!direct) begin
      value = pred + int'(res);
      if (value < 0) begin
        value = 0;
        clip = 1'b1;
      end else if (value > int'(cfg_gray)) begin
        value = int'(cfg_gray);
        clip = 1'b1;
      end
    end

    d.pixel   = value[7:0];
    d.clamped = clip;
    d.last    = at_last_col && at_last_row;

    if (col < MAX_W) row_mem[cur * MAX_W + col] = d.pixel;
    west2 = west;
    west  = int'(d.pixel);
    if (at_last_col) begin
      col_pos = 0;
      row_pos = at_last_row ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on each residual transfer, check each pixel transfer.
  // Sampled at the rising edge, so all values are the pre-edge ones.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    decoded_t want;
    if (!rst) begin
      if (item_valid && item_ready) begin
        want = decode_pixel(residual, mode_flag);
        if (tag_typed) begin
          want.pixel   = tag_pixel;
          want.clamped = tag_clamped;
        end
        pending_pixels.push_back(want);
      end
      if (result_valid && result_ready) begin
        pixels_seen++;
        if (pending_pixels.size() == 0) begin
          $error("pixel transfer with nothing expected: pixel %0d", pixel);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          if (pixel !== want.pixel) begin
            $error("pixel: expected %0d, got %0d", want.pixel, pixel);
            mismatches++;
          end
          if (clamped !== want.clamped) begin
            $error("clamped: expected %0b, got %0b", want.clamped, clamped);
            mismatches++;
          end
          if (last_pixel !== want.last) begin
            $error("last_pixel: expected %0b, got %0b", want.last, last_pixel);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver: random stalls on the pixel side.
  always @(posedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------

  // One residual transfer; valid holds with a stable payload until taken.
  task automatic send_pixel(input logic signed [10:0] res, input logic [1:0] mode,
                            input logic typed, input pixel_t px, input logic cl);
    while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    residual    <= res;
    mode_flag   <= mode;
    tag_typed   <= typed;
    tag_pixel   <= px;
    tag_clamped <= cl;
    do @(posedge clk); while (!item_ready);
    items_sent++;
  endtask

  // Stop sending and wait until every expected pixel has come back.
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (pixels_seen != items_sent);
  endtask

  // APB write: setup, access, then back to idle. Upper data bits are noise.
  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    logic [31:0] mask;
    case (idx)
      REG_PREDICT_RULE: mask = 32'h7;
      REG_IMAGE_WIDTH:  mask = 32'h7FF;
      REG_IMAGE_HEIGHT: mask = 32'h1FFF;
      default:          mask = 32'hFF;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (value & mask) | ($urandom & ~mask);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PREDICT_RULE: cfg_rule   = value[2:0];
      REG_IMAGE_WIDTH:  cfg_width  = value[10:0];
      REG_IMAGE_HEIGHT: cfg_height = value[12:0];
      default:          cfg_gray   = value[7:0];
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drain, then rewrite the whole register set.
  task automatic configure(input logic [2:0] rule, input logic [10:0] width,
                           input logic [12:0] height, input logic [7:0] gray);
    drain_results();
    write_reg(REG_PREDICT_RULE, 32'(rule));
    write_reg(REG_IMAGE_WIDTH, 32'(width));
    write_reg(REG_IMAGE_HEIGHT, 32'(height));
    write_reg(REG_MAX_GRAY, 32'(gray));
  endtask

  function automatic logic [2:0] pick_rule();
    // gradient rule most of the time, any 3-bit code otherwise
    return ($urandom_range(0, 9) < 5) ? RULE_GRADIENT : 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [7:0] pick_gray();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd1;
      2, 3:    return 8'($urandom_range(0, 255));
      default: return 8'd255;
    endcase
  endfunction

  // Style: 0 flat, 1 fine noise, 2 medium texture, 3 full-range residuals.
  task automatic send_random_pixel(input int style);
    logic signed [10:0] res;
    logic [1:0]         mode;
    case ($urandom_range(0, 9))
      0:       mode = MODE_COPY;
      1, 2:    mode = MODE_BINARY;
      3:       mode = MODE_SPARE;
      default: mode = MODE_CONT;
    endcase
    case (style)
      0:       res = ($urandom_range(0, 15) == 0) ? 11'($urandom) : '0;
      1:       res = 11'(int'($urandom_range(0, 8)) - 4);
      2:       res = 11'(int'($urandom_range(0, 80)) - 40);
      default: res = 11'($urandom);
    endcase
    send_pixel(res, mode, 1'b0, '0, 1'b0);
  endtask

  // A whole image at a fresh small setting; optional drain partway through.
  task automatic run_image_phase(input bit pause_mid);
    logic [10:0] wreg;
    logic [12:0] hreg;
    int          w_eff, h_eff, count, style, pause_at;
    case ($urandom_range(0, 19))
      0, 1:    wreg = 11'($urandom_range(0, 2));
      2:       wreg = 11'($urandom_range(13, 40));
      default: wreg = 11'($urandom_range(3, 12));
    endcase
    hreg  = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
    w_eff = (wreg < 3) ? 3 : int'(wreg);
    h_eff = (hreg == 0) ? 1 : int'(hreg);
    configure(pick_rule(), wreg, hreg, pick_gray());
    count    = w_eff * h_eff;
    pause_at = pause_mid ? $urandom_range(1, count - 1) : -1;
    style    = $urandom_range(0, 3);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain_results();
      send_random_pixel(style);
    end
    random_items += count;
  endtask

  // Very tall image cut short: after a few rows the height drops at or
  // below the current row, so that row finishes the image.
  task automatic run_tall_phase(input logic [12:0] hbig);
    logic [2:0] rule;
    logic [7:0] gray;
    int         w, rows_done, style;
    rule      = pick_rule();
    gray      = pick_gray();
    w         = $urandom_range(3, 6);
    rows_done = $urandom_range(2, 4);
    style     = $urandom_range(1, 3);
    configure(rule, 11'(w), hbig, gray);
    repeat (rows_done * w) send_random_pixel(style);
    configure(rule, 11'(w), 13'($urandom_range(0, rows_done + 1)), gray);
    repeat (w) send_random_pixel(style);
    random_items += (rows_done + 1) * w;
  endtask

  // Maximum width for part of row 0, then the width shrinks below the
  // current column: that pixel is taken as the last of its row.
  task automatic run_wide_phase(input logic [10:0] wbig);
    logic [2:0]  rule;
    logic [7:0]  gray;
    logic [10:0] wcut;
    int          k, h, w_eff, style;
    rule  = pick_rule();
    gray  = pick_gray();
    k     = $urandom_range(20, 60);
    h     = $urandom_range(2, 4);
    style = $urandom_range(0, 3);
    configure(rule, wbig, 13'(h), gray);
    repeat (k) send_random_pixel(style);
    wcut  = 11'($urandom_range(0, 12));
    w_eff = (wcut < 3) ? 3 : int'(wcut);
    configure(rule, wcut, 13'(h), gray);
    repeat (1 + (h - 1) * w_eff) send_random_pixel(style);
    random_items += k + 1 + (h - 1) * w_eff;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int  phase;
    bit  quiet;

    foreach (row_mem[i]) row_mem[i] = '0;

    // Directed table. Rows 0..3 run at reset settings in row 0; row 4 comes
    // after a switch to a 4x6 gradient image, so column 4 is past the new
    // last column. Rows 5..8 are row 1 (north). Column 2 of rows 2..5 is
    // interior: copy, binary pick, continuous, spare mode in that order.
    directed = '{
      '{11'sd1023,  MODE_SPARE,  1'b0, 1'b1, 8'd255, 1'b1},  // 128 + max
      '{11'h400,    MODE_COPY,   1'b0, 1'b1, 8'd0,   1'b1},  // most negative
      '{11'sd0,     MODE_BINARY, 1'b0, 1'b1, 8'd0,   1'b0},
      '{11'sd77,    MODE_CONT,   1'b0, 1'b1, 8'd77,  1'b0},
      '{-11'sd77,   MODE_CONT,   1'b1, 1'b1, 8'd0,   1'b0},
      '{11'sd0,     MODE_SPARE,  1'b0, 1'b1, 8'd255, 1'b0},
      '{11'sd1023,  MODE_COPY,   1'b0, 1'b1, 8'd255, 1'b1},
      '{-11'sd1,    MODE_BINARY, 1'b0, 1'b1, 8'd0,   1'b1},
      '{11'sd3,     MODE_CONT,   1'b0, 1'b1, 8'd80,  1'b0},
      '{-11'sd5,    MODE_CONT,   1'b0, 1'b0, 8'd0,   1'b0},
      '{-11'sd100,  MODE_CONT,   1'b0, 1'b0, 8'd0,   1'b0},
      '{11'sd500,   MODE_COPY,   1'b0, 1'b0, 8'd0,   1'b0},
      '{11'sd10,    MODE_CONT,   1'b0, 1'b0, 8'd0,   1'b0},
      '{11'sd0,     MODE_CONT,   1'b0, 1'b0, 8'd0,   1'b0},
      '{11'sd0,     MODE_CONT,   1'b0, 1'b0, 8'd0,   1'b0},
      '{11'sd300,   MODE_BINARY, 1'b0, 1'b0, 8'd0,   1'b0},
      '{-11'sd20,   MODE_CONT,   1'b0, 1'b0, 8'd0,   1'b0},
      '{11'sd1,     MODE_CONT,   1'b0, 1'b0, 8'd0,   1'b0},
      '{-11'sd1,    MODE_CONT,   1'b0, 1'b0, 8'd0,   1'b0},
      '{11'h400,    MODE_CONT,   1'b0, 1'b0, 8'd0,   1'b0},
      '{11'sd2,     MODE_CONT,   1'b0, 1'b0, 8'd0,   1'b0},
      '{11'sd0,     MODE_CONT,   1'b0, 1'b0, 8'd0,   1'b0},
      '{11'sd0,     MODE_CONT,   1'b0, 1'b0, 8'd0,   1'b0},
      '{11'sd1023,  MODE_SPARE,  1'b0, 1'b0, 8'd0,   1'b0},
      '{11'sd0,     MODE_CONT,   1'b0, 1'b0, 8'd0,   1'b0}   // last pixel
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].reconfig) configure(RULE_GRADIENT, 11'd4, 13'd6, 8'd255);
      send_pixel(directed[i].res, directed[i].mode, directed[i].typed,
                 directed[i].pixel, directed[i].clamped);
    end

    // Random images. Phases 12..19 run with no idling on either side; a few
    // phases take the size registers to their extremes.
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      quiet = (phase >= 12 && phase < 20);
      src_idle_pct  = quiet ? 0 : IDLE_PCT;
      sink_idle_pct = quiet ? 0 : IDLE_PCT;
      if (phase == 3) run_tall_phase(13'h1FFF);
      else if (phase == 23) run_tall_phase(13'd4096);
      else if (phase == 6) run_wide_phase(11'h7FF);
      else if (phase == 29) run_wide_phase(11'd1024);
      else run_image_phase(phase == 2 || $urandom_range(0, 15) == 0);
      phase++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $error("%0d expected pixels never arrived", pending_pixels.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
